// ===== rtl/tcca_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor advance: shared definitions
// Character codes, field widths, screen limit and register indexes.
// ----------------------------------------------------------------------------
package tcca_pkg;

   localparam int unsigned MAX_SCREEN = 4096;

   localparam int unsigned COL_W   = 14;
   localparam int unsigned ROW_W   = 13;
   localparam int unsigned SCR_W   = 13;
   localparam int unsigned SCALE_W = 4;
   localparam int unsigned TOP_W   = 12;
   localparam int unsigned CELL_W  = SCALE_W + 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;

   localparam logic [COL_W:0] COL_MAX = (COL_W+1)'(16383);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE       = 3'd0,
      REG_SCREEN_WIDTH = 3'd1,
      REG_SCREEN_HIGHT = 3'd2,
      REG_FONT_SCALE   = 3'd3,
      REG_TEXT_TOP     = 3'd4
   } reg_index_type;

endpackage

// ===== rtl/text_console_cursor_advance_unit.sv =====
// ----------------------------------------------------------------------------
// Text console cursor advance unit
// Keeps a pixel cursor, turns character bytes into draw and scroll commands.
// ----------------------------------------------------------------------------
// An accepted request word goes through the input register, then through the
// cursor update into the response register, to become its response word.
// Throughput: one word per cycle unless the response stalls; the cursor registers
// feed straight back into the single update stage, so only rsp_ready makes a character wait.
// Reset: cursor at (0, 0), console disabled, configuration at its defaults.
module text_console_cursor_advance_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_draw_valid,
   output logic [7:0]                          rsp_draw_char,
   output logic [tcca_pkg::COL_W-1:0]          rsp_draw_x,
   output logic [tcca_pkg::ROW_W-1:0]          rsp_draw_y,
   output logic                                rsp_scroll,
   output logic [tcca_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tcca_pkg::ROW_W-1:0]          rsp_cursor_row,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcca_pkg::CSR_DATA_W-1:0]     csr_data
);

   // configuration
   logic                              enable_ff;
   logic [tcca_pkg::SCR_W-1:0]        width_ff;
   logic [tcca_pkg::SCR_W-1:0]        height_ff;
   logic [tcca_pkg::SCALE_W-1:0]      scale_ff;
   logic [tcca_pkg::TOP_W-1:0]        top_ff;

   // input register
   logic                              in_valid_ff, in_valid_in;
   logic [7:0]                        in_char_ff;

   // cursor state
   logic [tcca_pkg::COL_W-1:0]        column_pos_ff, column_pos_in;
   logic [tcca_pkg::ROW_W-1:0]        row_pos_ff, row_pos_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_draw_valid_ff, rsp_draw_valid_in;
   logic [7:0]                        rsp_draw_char_ff, rsp_draw_char_in;
   logic [tcca_pkg::COL_W-1:0]        rsp_draw_x_ff, rsp_draw_x_in;
   logic [tcca_pkg::ROW_W-1:0]        rsp_draw_y_ff, rsp_draw_y_in;
   logic                              rsp_scroll_ff, rsp_scroll_in;

   logic                              advance;
   logic [tcca_pkg::SCR_W-1:0]        w_lim, h_lim;
   logic [tcca_pkg::CELL_W-1:0]       cw;
   logic [tcca_pkg::COL_W:0]          x0, cw_x, x_step, x_next, tab_step, tab_sum;
   logic [tcca_pkg::COL_W:0]          x_tab, x_adv;
   logic [tcca_pkg::ROW_W:0]          y0, cw_y, y_next, y_fin;
   logic                              draw, scroll_c;

   localparam logic [tcca_pkg::SCR_W-1:0] SCR_LIMIT = tcca_pkg::SCR_W'(tcca_pkg::MAX_SCREEN);

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign csr_ready   = 1'b1;

   always_comb begin
      w_lim = (width_ff > SCR_LIMIT) ? SCR_LIMIT : width_ff;
      h_lim = (height_ff > SCR_LIMIT) ? SCR_LIMIT : height_ff;
      cw    = {scale_ff, 3'b000};
      cw_x  = (tcca_pkg::COL_W+1)'(cw);
      cw_y  = (tcca_pkg::ROW_W+1)'(cw);
      x0    = {1'b0, column_pos_ff};
      // a row above the text area is first raised to its top line
      y0    = ({1'b0, row_pos_ff} < (tcca_pkg::ROW_W+1)'(top_ff)) ?
              (tcca_pkg::ROW_W+1)'(top_ff) : {1'b0, row_pos_ff};

      // tab: the mask is applied as written, even for a step that is not a power of two
      tab_step = {cw_x[tcca_pkg::COL_W-2:0], 2'b00};
      tab_sum  = (x0 + tab_step) & ~(tab_step - 1'b1);
      x_tab    = (tab_sum > tcca_pkg::COL_MAX) ? tcca_pkg::COL_MAX : tab_sum;
      x_adv    = x0 + cw_x;
      x_step   = x_adv + cw_x;

      draw   = 1'b0;
      x_next = x0;
      y_next = y0;
      case (in_char_ff)
         tcca_pkg::CH_NEWLINE: begin
            x_next = '0;
            y_next = y0 + cw_y;
         end
         tcca_pkg::CH_RETURN: begin
            x_next = '0;
         end
         tcca_pkg::CH_BACKSPACE: begin
            if (x0 >= cw_x) begin
               x_next = x0 - cw_x;
            end
         end
         tcca_pkg::CH_TAB: begin
            x_next = x_tab;
         end
         default: begin
            draw = 1'b1;
            if (x_step > (tcca_pkg::COL_W+1)'(w_lim)) begin
               x_next = '0;
               y_next = y0 + cw_y;
            end else begin
               x_next = x_adv;
            end
         end
      endcase

      scroll_c = (y_next + cw_y) > (tcca_pkg::ROW_W+1)'(h_lim);
      if (scroll_c) begin
         y_fin = (y_next >= cw_y) ? (y_next - cw_y) : '0;
      end else begin
         y_fin = y_next;
      end

      column_pos_in     = column_pos_ff;
      row_pos_in        = row_pos_ff;
      rsp_draw_valid_in = 1'b0;
      rsp_draw_char_in  = '0;
      rsp_draw_x_in     = '0;
      rsp_draw_y_in     = '0;
      rsp_scroll_in     = 1'b0;
      if (advance && enable_ff) begin
         column_pos_in     = x_next[tcca_pkg::COL_W-1:0];
         row_pos_in        = y_fin[tcca_pkg::ROW_W-1:0];
         rsp_draw_valid_in = draw;
         rsp_draw_char_in  = draw ? in_char_ff : 8'd0;
         rsp_draw_x_in     = draw ? column_pos_ff : '0;
         rsp_draw_y_in     = draw ? y0[tcca_pkg::ROW_W-1:0] : '0;
         rsp_scroll_in     = scroll_c;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         width_ff      <= tcca_pkg::SCR_W'(1024);
         height_ff     <= tcca_pkg::SCR_W'(768);
         scale_ff      <= tcca_pkg::SCALE_W'(2);
         top_ff        <= tcca_pkg::TOP_W'(32);
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tcca_pkg::REG_ENABLE:       enable_ff <= csr_data[0];
               tcca_pkg::REG_SCREEN_WIDTH: width_ff  <= csr_data;
               tcca_pkg::REG_SCREEN_HIGHT: height_ff <= csr_data;
               tcca_pkg::REG_FONT_SCALE:   scale_ff  <= csr_data[tcca_pkg::SCALE_W-1:0];
               tcca_pkg::REG_TEXT_TOP:     top_ff    <= csr_data[tcca_pkg::TOP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_char_ff <= req_char_code;
      end
      if (advance) begin
         rsp_draw_valid_ff <= rsp_draw_valid_in;
         rsp_draw_char_ff  <= rsp_draw_char_in;
         rsp_draw_x_ff     <= rsp_draw_x_in;
         rsp_draw_y_ff     <= rsp_draw_y_in;
         rsp_scroll_ff     <= rsp_scroll_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_draw_valid = rsp_draw_valid_ff;
   assign rsp_draw_char  = rsp_draw_char_ff;
   assign rsp_draw_x     = rsp_draw_x_ff;
   assign rsp_draw_y     = rsp_draw_y_ff;
   assign rsp_scroll     = rsp_scroll_ff;
   // the response always reports the cursor as it now stands
   assign rsp_cursor_col = column_pos_ff;
   assign rsp_cursor_row = row_pos_ff;

`ifndef NO_ASSERTIONS
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && !enable_ff |=> rsp_valid && !rsp_draw_valid && !rsp_scroll)
      else $error("disabled console produced a draw or scroll command");

   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(column_pos_ff) && $stable(row_pos_ff))
      else $error("cursor moved without a word being processed");

   a_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("stalled input word was lost or changed");

   a_no_draw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_draw_valid |->
         rsp_draw_char == 8'd0 && rsp_draw_x == '0 && rsp_draw_y == '0)
      else $error("draw fields not cleared for a word without a glyph");
`endif

endmodule
